FILE: rtl/sida_pkg.sv
// Package with widths, constants and control types for the decimal text converter.
package sida_pkg;

  // Width of the signed input value.
  localparam int VALUE_BITS = 32;
  // Decimal digits needed for the largest magnitude: ceil(VALUE_BITS * log10(2)).
  localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int BCD_W = DIGITS * 4;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_STRIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift_bin;
    logic strip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic rem_last;
    logic out_free;
    logic neg;
  } status_t;

endpackage

FILE: rtl/sida_datapath.sv
// Datapath: magnitude and BCD registers, shift-add-3 conversion and output register.
module sida_datapath
  import sida_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            character,
  output logic                  last
);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic [REM_W-1:0]      remaining;
  logic                  neg;
  logic [3:0]            top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    bcd_adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
    end
  end

  // Conversion registers: load, shift in the binary magnitude, then drop digits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg       <= value[VALUE_BITS-1];
      mag       <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
      bcd       <= '0;
      cnt       <= '0;
      remaining <= REM_W'(DIGITS);
    end else if (cmd.shift_bin) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.strip || cmd.emit_digit) begin
      bcd       <= {bcd[BCD_W-5:0], 4'd0};
      remaining <= remaining - REM_W'(1);
    end
  end

  // Output register holds one character until its transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= CHAR_ZERO + {4'd0, top_digit};
      last      <= (remaining == REM_W'(1));
    end
  end

  // Status back to the controller.
  always_comb begin
    status.conv_done = (cnt == CNT_W'(VALUE_BITS - 1));
    status.top_zero  = (top_digit == 4'd0);
    status.rem_last  = (remaining == REM_W'(1));
    status.out_free  = !out_valid || !out_stall;
    status.neg       = neg;
  end

endmodule

FILE: rtl/sida_controller.sv
// Controller state machine that sequences conversion, zero stripping and output.
module sida_controller
  import sida_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.conv_done) state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (!status.top_zero || status.rem_last) begin
          state_next = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status.out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.rem_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.shift_bin = 1'b1;
      ST_STRIP:   cmd.strip = status.top_zero && !status.rem_last;
      ST_SIGN:    cmd.emit_sign = status.out_free;
      ST_EMIT:    cmd.emit_digit = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: a signed integer in, its decimal ASCII text out one character per transaction.
// An accepted value runs through the shift-add-3 BCD loop, shifting in every magnitude bit,
// then leading zero digits are dropped one at a time, then each character is emitted.
// A new value is taken once the last character is in the output register; until then
// in_stall is held high, and while the output stalls, characters are held back.
// Synchronous active-high reset clears the controller state and the output valid flag.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            character,
  output logic                  last
);

  cmd_t    cmd;
  status_t status;

  sida_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sida_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

FILE: tb/sv/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;
  import sida_pkg::*;

  // Longest text: a sign and DIGITS digits, packed right-justified, zero bytes unused.
  localparam int TEXT_LEN = DIGITS + 1;
  localparam int TEXT_W = 8 * TEXT_LEN;
  localparam int RANDOM_VALUES = 110;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 40;
  localparam int DRAIN_CYCLES = 60;
  localparam int TIMEOUT_NS = 20_000_000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] v;
    logic [TEXT_W-1:0]     text;
  } text_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            character;
  logic                  last;

  // Characters still owed by the block, oldest first.
  text_char_t        expected_text[$];
  // Typed-in text per offered value; zero means the predictor supplies it.
  logic [TEXT_W-1:0] typed_texts[$];
  text_row_t         directed_rows[$];

  int errors = 0;
  int values_converted = 0;
  int negatives_seen = 0;
  int zeros_seen = 0;
  int chars_checked = 0;
  int longest_text = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;

  signed_int_to_decimal_ascii u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .character(character),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

  // Decimal text of a two's complement value, packed right-justified.
  function automatic logic [TEXT_W-1:0] decimal_text(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] rem;
    logic [TEXT_W-1:0]     txt;
    int                    n;
    txt = '0;
    n = 0;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      rem = mag % 10;
      txt[8*n +: 8] = CHAR_ZERO + rem[7:0];
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (v[VALUE_BITS-1]) txt[8*n +: 8] = CHAR_MINUS;
    return txt;
  endfunction

  // Turn packed text into expected characters, flagging the final one.
  function automatic void queue_text(input logic [TEXT_W-1:0] txt);
    logic [7:0] chars[$];
    int         i;
    for (i = TEXT_LEN - 1; i >= 0; i--) begin
      if (txt[8*i +: 8] != 8'd0) chars.push_back(txt[8*i +: 8]);
    end
    for (i = 0; i < chars.size(); i++) begin
      expected_text.push_back({chars[i], i == chars.size() - 1});
    end
    if (chars.size() > longest_text) longest_text = chars.size();
  endfunction

  // Watch both channels: predict on each input transaction, check each output one.
  always @(posedge clk) begin : watch_channels
    logic [TEXT_W-1:0] typed;
    text_char_t        want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        typed = typed_texts.pop_front();
        queue_text(typed != '0 ? typed : decimal_text(value));
        values_converted++;
        if (value[VALUE_BITS-1]) negatives_seen++;
        if (value == '0) zeros_seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character transaction: character %0d last %0b", character, last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (character !== want.ch) begin
            $error("character: expected %0d, got %0d", want.ch, character);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
          end
        end
      end
    end
  end

  // Offer one value, with a random gap whenever a burst runs out.
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic [TEXT_W-1:0] txt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    typed_texts.push_back(txt);
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering until every owed character has arrived.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [VALUE_BITS-1:0] v, input logic [TEXT_W-1:0] txt);
    directed_rows.push_back({v, txt});
  endtask

  // Receiver: phases of free flow, random and periodic stalls, plus one long hold-off.
  initial begin : receiver
    int kind;
    int len;
    int k;
    forever begin
      if (!hold_done && values_converted >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 3);
      len = $urandom_range(5, 60);
      k = $urandom_range(2, 5);
      for (int c = 0; c < len; c++) begin
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (c % k == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Sender: reset, directed table, then random values, then drain and report.
  initial begin : sender
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    int                    mode;

    // Directed rows: extremes and digit-count boundaries.
    add_row(32'd0, "0");
    add_row(32'd1, "1");
    add_row(-32'sd1, "-1");
    add_row(32'd9, "9");
    add_row(32'd10, "10");
    add_row(-32'sd9, "-9");
    add_row(-32'sd10, "-10");
    add_row(32'd99, '0);
    add_row(32'd100, '0);
    add_row(32'd2147483647, "2147483647");
    add_row(-32'sd2147483647, "-2147483647");
    add_row(32'h8000_0000, "-2147483648");
    add_row(32'd1000000000, "1000000000");
    add_row(32'd999999999, '0);
    add_row(-32'sd1000000000, '0);
    add_row(-32'sd214748364, '0);
    add_row(32'd2147483640, '0);
    add_row(32'h5555_5555, '0);
    add_row(32'hAAAA_AAAA, '0);
    add_row(32'd12345, '0);
    add_row(-32'sd54321, '0);
    add_row(32'd0, "0");

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_value(directed_rows[i].v, directed_rows[i].text);
    pause_until_drained();

    // Random values: full range, tiny values, near powers of ten, and random lengths.
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: v = $urandom;
        1: v = $urandom_range(0, 12);
        2: begin
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          v = p + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if (mode != 0 && $urandom_range(0, 1) == 1) v = -v;
      send_value(v, '0);
      if (i == RANDOM_VALUES / 2) pause_until_drained();
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text.size());
      errors++;
    end

    $display("Converted %0d values (%0d negative, %0d zero) into %0d checked characters.",
             values_converted, negatives_seen, zeros_seen, chars_checked);
    $display("Longest text was %0d characters; receiver held off for %0d cycles once.",
             longest_text, HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sida_pkg.sv
rtl/sida_datapath.sv
rtl/sida_controller.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
